### src/prig_pkg.sv
// Shared types and constants for the Philox ranged integer generator.
// Used by every module in src; depends on nothing.
`default_nettype none
package prig_pkg;

    localparam int DEF_ROUNDS  = 10;
    localparam int QUEUE_DEPTH = 4;
    localparam int DIV_STAGES  = 64;
    localparam int ADDR_W      = 5;

    localparam logic [31:0] MUL_A  = 32'hD2511F53;
    localparam logic [31:0] MUL_B  = 32'hCD9E8D57;
    localparam logic [31:0] BUMP_A = 32'h9E3779B9;
    localparam logic [31:0] BUMP_B = 32'hBB67AE85;

    typedef enum logic [1:0] {
        REG_RAW_MODE    = 2'd0,
        REG_SAMPLE_WIDE = 2'd1,
        REG_LOW_VALUE   = 2'd2,
        REG_RANGE_SIZE  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [63:0] seed;
        logic [63:0] counter_offset;
        logic [62:0] chunk_index;
        logic [2:0]  element_count;
    } cmd_t;

    typedef struct packed {
        logic [63:0] value0;
        logic [63:0] value1;
        logic [63:0] value2;
        logic [63:0] value3;
        logic [2:0]  valid_count;
    } result_t;

    typedef struct packed {
        logic        raw_mode;
        logic        sample_wide;
        logic [63:0] low_value;
        logic [63:0] range_size;
    } cfg_t;

    typedef struct packed {
        logic [63:0] counter;
        logic [63:0] key;
        logic [2:0]  count;
    } job_t;

    typedef struct packed {
        logic [31:0] c0;
        logic [31:0] c1;
        logic [31:0] c2;
        logic [31:0] c3;
        logic [63:0] key;
        logic [2:0]  count;
    } round_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] count;
    } tag_t;

endpackage
`default_nettype wire

### src/prig_front.sv
// Front end: configuration registers, command acceptance, counter formation
// and count saturation. Depends on prig_pkg.
`default_nettype none
module prig_front
    import prig_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [63:0]       pwdata,
    output logic      [63:0]       prdata,
    input  wire logic              start,
    input  wire cmd_t              cmd,
    output logic                   busy,
    input  wire logic              q_full,
    output logic                   job_valid,
    output job_t                   job,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       valid_reg;
    logic       valid_next;
    job_t       job_reg;
    job_t       job_next;
    reg_idx_t   idx;
    logic       wr_en;
    logic       accept;
    logic       push;
    logic [2:0] cnt;
    logic [2:0] maxc;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign busy   = valid_reg && q_full;
    assign accept = start && !busy;
    assign push   = valid_reg && !q_full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_RAW_MODE:    cfg_next.raw_mode    = pwdata[0];
                REG_SAMPLE_WIDE: cfg_next.sample_wide = pwdata[0];
                REG_LOW_VALUE:   cfg_next.low_value   = pwdata;
                REG_RANGE_SIZE:  cfg_next.range_size  = pwdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_RAW_MODE:    prdata = {63'd0, cfg_reg.raw_mode};
            REG_SAMPLE_WIDE: prdata = {63'd0, cfg_reg.sample_wide};
            REG_LOW_VALUE:   prdata = cfg_reg.low_value;
            REG_RANGE_SIZE:  prdata = cfg_reg.range_size;
            default:         prdata = 64'd0;
        endcase
    end

    // A count of zero acts as one; the ceiling depends on the sample width.
    always_comb
    begin
        maxc = cfg_reg.sample_wide ? 3'd2 : 3'd4;
        cnt  = cmd.element_count;
        if (cnt == 3'd0)
        begin
            cnt = 3'd1;
        end
        if (cnt > maxc)
        begin
            cnt = maxc;
        end
        job_next.counter = cmd.counter_offset + {1'b0, cmd.chunk_index};
        job_next.key     = cmd.seed;
        job_next.count   = cnt;
        valid_next       = accept ? 1'b1 : (push ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= '{raw_mode: 1'b1, sample_wide: 1'b0,
                           low_value: 64'd0, range_size: 64'd0};
            valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = push;
    assign job       = job_reg;
    assign cfg       = cfg_reg;

endmodule
`default_nettype wire

### src/prig_queue.sv
// Short queue between the front end and the generation pipeline.
// Depends on prig_pkg.
`default_nettype none
module prig_queue
    import prig_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_data,
    output logic      full,
    output logic      pop_valid,
    output job_t      pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t               store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;
    logic               pop;

    // The pipeline behind never stalls, so any held transaction leaves at once.
    assign pop       = (fill_reg != '0);
    assign pop_valid = pop;
    assign pop_data  = store_reg[rd_ptr_reg];
    assign full      = (fill_reg == CNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

### src/prig_round.sv
// One registered Philox4x32 round with the key bump for the following round.
// Depends on prig_pkg.
`default_nettype none
module prig_round
    import prig_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    input  wire round_t in_data,
    output logic        out_valid,
    output round_t      out_data
);

    logic [63:0] pa;
    logic [63:0] pb;
    round_t      data_next;
    logic        valid_reg;
    round_t      data_reg;

    always_comb
    begin
        pa = 64'(MUL_A) * 64'(in_data.c0);
        pb = 64'(MUL_B) * 64'(in_data.c2);
        data_next.c0    = pb[63:32] ^ in_data.c1 ^ in_data.key[31:0];
        data_next.c1    = pb[31:0];
        data_next.c2    = pa[63:32] ^ in_data.c3 ^ in_data.key[63:32];
        data_next.c3    = pa[31:0];
        data_next.key   = {in_data.key[63:32] + BUMP_B, in_data.key[31:0] + BUMP_A};
        data_next.count = in_data.count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

### src/prig_reduce.sv
// One sample lane: pipelined restoring remainder, one dividend bit per stage,
// then the offset add. Depends on prig_pkg.
`default_nettype none
module prig_reduce
    import prig_pkg::*;
(
    input  wire logic        clk,
    input  wire logic [63:0] sample,
    input  wire cfg_t        cfg,
    output logic [63:0]      value
);

    logic [63:0] rem_reg [DIV_STAGES];
    logic [63:0] dvd_reg [DIV_STAGES];
    logic [63:0] raw_reg [DIV_STAGES];
    logic [63:0] value_reg;
    logic [63:0] rng;
    logic        bypass;

    function automatic logic [63:0] rem_step(input logic [63:0] r, input logic b,
                                             input logic [63:0] d);
        logic [64:0] t;
        t = {r, b};
        if (t >= {1'b0, d})
        begin
            t = t - {1'b0, d};
        end
        return t[63:0];
    endfunction

    // Narrow samples arrive zero-extended, so a 64-bit remainder serves both modes.
    assign rng    = cfg.sample_wide ? cfg.range_size : {32'd0, cfg.range_size[31:0]};
    assign bypass = cfg.raw_mode || (rng == 64'd0);

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= rem_step(64'd0, sample[63], rng);
        dvd_reg[0] <= {sample[62:0], 1'b0};
        raw_reg[0] <= sample;
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            rem_reg[i] <= rem_step(rem_reg[i-1], dvd_reg[i-1][63], rng);
            dvd_reg[i] <= {dvd_reg[i-1][62:0], 1'b0};
            raw_reg[i] <= raw_reg[i-1];
        end
        if (bypass)
        begin
            value_reg <= raw_reg[DIV_STAGES-1];
        end
        else if (cfg.sample_wide)
        begin
            value_reg <= cfg.low_value + rem_reg[DIV_STAGES-1];
        end
        else
        begin
            value_reg <= {32'd0, cfg.low_value[31:0] + rem_reg[DIV_STAGES-1][31:0]};
        end
    end

    assign value = value_reg;

endmodule
`default_nettype wire

### src/philox_ranged_integer_generator.sv
// Philox4x32 ranged integer generator, top level.
// Throughput: one transaction per cycle; the round and remainder pipelines are
// fully pipelined and the receiver cannot stall, so busy stays low in use.
// Reset (rst_n, asynchronous, active low) empties the pipeline and restores
// raw_mode = 1, sample_wide = 0, low_value = 0, range_size = 0.
`default_nettype none
module philox_ranged_integer_generator
    import prig_pkg::*;
#(
    parameter int PHILOX_ROUNDS = DEF_ROUNDS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [63:0]       pwdata,
    output logic      [63:0]       prdata,
    output logic                   pready,
    input  wire logic              start,
    input  wire cmd_t              cmd,
    output logic                   busy,
    output logic                   done,
    output result_t                result
);

    localparam int LANE_LAT = DIV_STAGES + 1;

    cfg_t        cfg;
    logic        q_full;
    logic        job_valid;
    job_t        job;
    logic        q_valid;
    job_t        q_data;
    logic        rnd_valid [PHILOX_ROUNDS+1];
    round_t      rnd       [PHILOX_ROUNDS+1];
    logic [63:0] lane_in   [4];
    logic [63:0] lane_out  [4];
    tag_t        tag_reg   [LANE_LAT];
    logic        done_reg;
    result_t     result_reg;
    result_t     result_next;
    round_t      last;

    assign pready = 1'b1;

    prig_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .q_full    (q_full),
        .job_valid (job_valid),
        .job       (job),
        .cfg       (cfg)
    );

    prig_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_valid),
        .push_data (job),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    assign rnd_valid[0] = q_valid;
    assign rnd[0]       = '{c0: q_data.counter[31:0], c1: q_data.counter[63:32],
                            c2: 32'd0, c3: 32'd0, key: q_data.key,
                            count: q_data.count};

    for (genvar r = 0; r < PHILOX_ROUNDS; r++)
    begin : g_round
        prig_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (rnd_valid[r]),
            .in_data   (rnd[r]),
            .out_valid (rnd_valid[r+1]),
            .out_data  (rnd[r+1])
        );
    end

    assign last = rnd[PHILOX_ROUNDS];

    always_comb
    begin
        if (cfg.sample_wide)
        begin
            lane_in[0] = {last.c0, last.c1};
            lane_in[1] = {last.c2, last.c3};
            lane_in[2] = 64'd0;
            lane_in[3] = 64'd0;
        end
        else
        begin
            lane_in[0] = {32'd0, last.c0};
            lane_in[1] = {32'd0, last.c1};
            lane_in[2] = {32'd0, last.c2};
            lane_in[3] = {32'd0, last.c3};
        end
    end

    for (genvar j = 0; j < 4; j++)
    begin : g_lane
        prig_reduce u_reduce (
            .clk    (clk),
            .sample (lane_in[j]),
            .cfg    (cfg),
            .value  (lane_out[j])
        );
    end

    // Valid and count follow the lanes through a matching delay line.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_LAT; i++)
            begin
                tag_reg[i] <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            tag_reg[0] <= '{valid: rnd_valid[PHILOX_ROUNDS], count: last.count};
            for (int i = 1; i < LANE_LAT; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
            done_reg <= tag_reg[LANE_LAT-1].valid;
        end
    end

    always_comb
    begin
        result_next.value0      = lane_out[0];
        result_next.value1      = (tag_reg[LANE_LAT-1].count > 3'd1) ? lane_out[1] : 64'd0;
        result_next.value2      = (tag_reg[LANE_LAT-1].count > 3'd2 && !cfg.sample_wide)
                                  ? lane_out[2] : 64'd0;
        result_next.value3      = (tag_reg[LANE_LAT-1].count > 3'd3 && !cfg.sample_wide)
                                  ? lane_out[3] : 64'd0;
        result_next.valid_count = tag_reg[LANE_LAT-1].count;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire
